// ===== hdl/pbr_pkg.sv =====
// Package: shared constants, types and a saturating increment for the page buffer replacement block
package pbr_pkg;
   localparam int NUM_FRAMES_DEFAULT = 64;
   localparam int CfDivisor = 3;
   localparam int PageWidth = 32;
   localparam int StampWidth = 32;
   localparam int CountWidth = 32;
   localparam int FrameOutWidth = 6;
   localparam int PolicyWidth = 2;

   typedef enum logic [1:0] {
      POLICY_LRU = 2'd0,
      POLICY_CFLRU = 2'd1,
      POLICY_WSR = 2'd2,
      POLICY_SPARE = 2'd3
   } policy_type;

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction
endpackage

// ===== hdl/pbr_frame_store.sv =====
// Frame table memories: page, stamp, dirty and cold per frame
module pbr_frame_store #(
   parameter int NUM_FRAMES = pbr_pkg::NUM_FRAMES_DEFAULT,
   parameter int IdxWidth = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
   input  logic                           clock,
   input  logic [IdxWidth-1:0]            rd_addr,
   output logic [pbr_pkg::PageWidth-1:0]  rd_page,
   output logic [pbr_pkg::StampWidth-1:0] rd_stamp,
   output logic                           rd_dirty,
   output logic                           rd_cold,
   input  logic                           wr_en,
   input  logic [IdxWidth-1:0]            wr_addr,
   input  logic [pbr_pkg::PageWidth-1:0]  wr_page,
   input  logic [pbr_pkg::StampWidth-1:0] wr_stamp,
   input  logic                           wr_dirty,
   input  logic                           wr_cold
);
   localparam int EntryWidth = pbr_pkg::PageWidth + pbr_pkg::StampWidth + 2;
   logic [EntryWidth-1:0] mem [NUM_FRAMES];
   logic [EntryWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_page, wr_stamp, wr_dirty, wr_cold};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign {rd_page, rd_stamp, rd_dirty, rd_cold} = rd_data_ff;
endmodule

// ===== hdl/page_buffer_replacement.sv =====
// Top level: page buffer with LRU, clean-first LRU and LRU-WSR replacement
// A request is taken when start is high and busy is low; the result appears
// for one cycle with rsp_valid and cannot be stalled. A hit costs one scan
// pass up to the matching frame; a miss with free frames costs a lookup
// pass over the filled frames; a miss in a full buffer adds one victim pass
// (LRU), two or three passes (clean-first), or one pass plus one more per
// second chance given (LRU-WSR). All passes go through the single read port
// of the frame table; the victim passes share one age compare unit. No
// clearing pass after reset.
module page_buffer_replacement #(
   parameter int NUM_FRAMES = pbr_pkg::NUM_FRAMES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_type,
   input  logic [pbr_pkg::PageWidth-1:0]      req_page_id,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pbr_pkg::PolicyWidth-1:0]    csr_policy,
   output logic                               rsp_valid,
   output logic [pbr_pkg::FrameOutWidth-1:0]  rsp_frame_index,
   output logic                               rsp_hit,
   output logic                               rsp_read_fetch,
   output logic                               rsp_evicted,
   output logic                               rsp_writeback,
   output logic [pbr_pkg::PageWidth-1:0]      rsp_evicted_page,
   output logic [pbr_pkg::CountWidth-1:0]     rsp_hits_total,
   output logic [pbr_pkg::CountWidth-1:0]     rsp_misses_total,
   output logic [pbr_pkg::CountWidth-1:0]     rsp_reads_total,
   output logic [pbr_pkg::CountWidth-1:0]     rsp_writebacks_total
);
   localparam int IdxWidth = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CntWidth = $clog2(NUM_FRAMES + 1);
   localparam int RegionRaw = NUM_FRAMES / pbr_pkg::CfDivisor;
   localparam int Region = (RegionRaw == 0) ? 1 : RegionRaw;
   localparam logic [CntWidth-1:0] NumFramesC = CntWidth'(NUM_FRAMES);
   localparam logic [CntWidth-1:0] RegionC = CntWidth'(Region);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOOK, ST_OLD, ST_CLEAN, ST_RANK, ST_WSR_CHK, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [CntWidth-1:0] filled_ff, filled_in;
   logic [pbr_pkg::StampWidth-1:0] clock_ff, clock_in;
   logic [pbr_pkg::CountWidth-1:0] hitc_ff, hitc_in, missc_ff, missc_in;
   logic [pbr_pkg::CountWidth-1:0] readc_ff, readc_in, wbc_ff, wbc_in;
   logic [pbr_pkg::PolicyWidth-1:0] policy_ff, policy_in;
   logic is_write_ff, is_write_in;
   logic [pbr_pkg::PageWidth-1:0] page_ff, page_in;
   logic [CntWidth-1:0] issue_ff, issue_in;
   logic [CntWidth-1:0] chk_ff, chk_in;
   logic chk_valid_ff, chk_valid_in;
   logic [IdxWidth-1:0] best_ff, best_in;
   logic [pbr_pkg::StampWidth-1:0] best_stamp_ff, best_stamp_in;
   logic best_dirty_ff, best_dirty_in, best_cold_ff, best_cold_in;
   logic [pbr_pkg::PageWidth-1:0] best_page_ff, best_page_in;
   logic have_ff, have_in;
   logic [CntWidth-1:0] rank_ff, rank_in;
   logic [IdxWidth-1:0] frame_ff, frame_in;
   logic hit_ff, hit_in, ev_ff, ev_in, wb_ff, wb_in;
   logic [pbr_pkg::PageWidth-1:0] evp_ff, evp_in;

   logic [IdxWidth-1:0] rd_addr;
   logic [pbr_pkg::PageWidth-1:0] rd_page;
   logic [pbr_pkg::StampWidth-1:0] rd_stamp;
   logic rd_dirty, rd_cold;
   logic wr_en, wr_dirty, wr_cold;
   logic [IdxWidth-1:0] wr_addr;
   logic [pbr_pkg::PageWidth-1:0] wr_page;
   logic [pbr_pkg::StampWidth-1:0] wr_stamp;

   pbr_frame_store #(.NUM_FRAMES(NUM_FRAMES), .IdxWidth(IdxWidth)) u_store (
      .clock(clock), .rd_addr(rd_addr), .rd_page(rd_page), .rd_stamp(rd_stamp),
      .rd_dirty(rd_dirty), .rd_cold(rd_cold), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_page(wr_page), .wr_stamp(wr_stamp), .wr_dirty(wr_dirty), .wr_cold(wr_cold)
   );

   logic [IdxWidth-1:0] chk_idx;
   logic rd_older;
   logic scan_end;

   assign chk_idx = chk_ff[IdxWidth-1:0];
   assign rd_addr = (state_ff == ST_IDLE || issue_ff >= NumFramesC) ?
                    '0 : issue_ff[IdxWidth-1:0];
   assign rd_older = (rd_stamp < best_stamp_ff) ||
                     ((rd_stamp == best_stamp_ff) && (chk_idx < best_ff));
   assign scan_end = chk_valid_ff && (chk_ff == NumFramesC - 1'b1);
   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE) && !start;

   always_comb begin
      state_in = state_ff;
      filled_in = filled_ff;
      clock_in = clock_ff;
      hitc_in = hitc_ff;
      missc_in = missc_ff;
      readc_in = readc_ff;
      wbc_in = wbc_ff;
      policy_in = policy_ff;
      is_write_in = is_write_ff;
      page_in = page_ff;
      issue_in = issue_ff;
      chk_in = chk_ff;
      chk_valid_in = 1'b0;
      best_in = best_ff;
      best_stamp_in = best_stamp_ff;
      best_dirty_in = best_dirty_ff;
      best_cold_in = best_cold_ff;
      best_page_in = best_page_ff;
      have_in = have_ff;
      rank_in = rank_ff;
      frame_in = frame_ff;
      hit_in = hit_ff;
      ev_in = ev_ff;
      wb_in = wb_ff;
      evp_in = evp_ff;
      wr_en = 1'b0;
      wr_addr = frame_ff;
      wr_page = page_ff;
      wr_stamp = clock_ff;
      wr_dirty = is_write_ff;
      wr_cold = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid && csr_ready) begin
               policy_in = csr_policy;
            end
            if (start) begin
               is_write_in = req_type;
               page_in = req_page_id;
               hit_in = 1'b0;
               ev_in = 1'b0;
               wb_in = 1'b0;
               evp_in = '0;
               issue_in = '0;
               chk_in = '0;
               if (filled_ff != '0) begin
                  issue_in = CntWidth'(1);
                  chk_valid_in = 1'b1;
               end
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (chk_valid_ff && rd_page == page_ff) begin
               hit_in = 1'b1;
               frame_in = chk_idx;
               hitc_in = pbr_pkg::sat_inc(hitc_ff);
               wr_en = 1'b1;
               wr_addr = chk_idx;
               wr_page = rd_page;
               wr_dirty = rd_dirty | is_write_ff;
               state_in = ST_DONE;
            end else if (issue_ff < filled_ff) begin
               chk_valid_in = 1'b1;
               chk_in = issue_ff;
               issue_in = issue_ff + 1'b1;
            end else if (!chk_valid_ff) begin
               missc_in = pbr_pkg::sat_inc(missc_ff);
               if (!is_write_ff) begin
                  readc_in = pbr_pkg::sat_inc(readc_ff);
               end
               if (filled_ff < NumFramesC) begin
                  frame_in = filled_ff[IdxWidth-1:0];
                  filled_in = filled_ff + 1'b1;
                  wr_en = 1'b1;
                  wr_addr = filled_ff[IdxWidth-1:0];
                  state_in = ST_DONE;
               end else begin
                  best_stamp_in = '1;
                  best_in = '1;
                  have_in = 1'b0;
                  issue_in = CntWidth'(1);
                  chk_in = '0;
                  chk_valid_in = 1'b1;
                  state_in = (policy_ff == pbr_pkg::POLICY_CFLRU) ? ST_CLEAN : ST_OLD;
               end
            end
         end
         ST_OLD, ST_CLEAN: begin
            if (chk_valid_ff) begin
               if ((!have_ff || rd_older) &&
                   !(state_ff == ST_CLEAN && rd_dirty)) begin
                  have_in = 1'b1;
                  best_in = chk_idx;
                  best_stamp_in = rd_stamp;
                  best_dirty_in = rd_dirty;
                  best_cold_in = rd_cold;
                  best_page_in = rd_page;
               end
            end
            if (issue_ff < NumFramesC) begin
               chk_valid_in = 1'b1;
               chk_in = issue_ff;
               issue_in = issue_ff + 1'b1;
            end
            if (scan_end) begin
               issue_in = CntWidth'(1);
               chk_in = '0;
               chk_valid_in = 1'b1;
               if (state_ff == ST_CLEAN) begin
                  rank_in = '0;
                  if (have_in) begin
                     state_in = ST_RANK;
                  end else begin
                     have_in = 1'b0;
                     best_stamp_in = '1;
                     best_in = '1;
                     state_in = ST_OLD;
                  end
               end else begin
                  chk_valid_in = 1'b0;
                  state_in = ST_WSR_CHK;
               end
            end
         end
         ST_RANK: begin
            if (chk_valid_ff && rd_older) begin
               rank_in = rank_ff + 1'b1;
            end
            if (issue_ff < NumFramesC) begin
               chk_valid_in = 1'b1;
               chk_in = issue_ff;
               issue_in = issue_ff + 1'b1;
            end
            if (scan_end) begin
               if (rank_in < RegionC) begin
                  chk_valid_in = 1'b0;
                  state_in = ST_WSR_CHK;
               end else begin
                  have_in = 1'b0;
                  best_stamp_in = '1;
                  best_in = '1;
                  issue_in = CntWidth'(1);
                  chk_in = '0;
                  chk_valid_in = 1'b1;
                  state_in = ST_OLD;
               end
            end
         end
         ST_WSR_CHK: begin
            if (policy_ff == pbr_pkg::POLICY_WSR && best_dirty_ff && !best_cold_ff) begin
               wr_en = 1'b1;
               wr_addr = best_ff;
               wr_page = best_page_ff;
               wr_stamp = clock_ff;
               wr_dirty = 1'b1;
               wr_cold = 1'b1;
               clock_in = clock_ff + 1'b1;
               have_in = 1'b0;
               best_stamp_in = '1;
               best_in = '1;
               issue_in = '0;
               chk_in = '0;
               chk_valid_in = 1'b0;
               state_in = ST_OLD;
            end else begin
               frame_in = best_ff;
               ev_in = 1'b1;
               evp_in = best_page_ff;
               if (best_dirty_ff) begin
                  wb_in = 1'b1;
                  wbc_in = pbr_pkg::sat_inc(wbc_ff);
               end
               wr_en = 1'b1;
               wr_addr = best_ff;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            clock_in = clock_ff + 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         filled_ff <= '0;
         clock_ff <= '0;
         hitc_ff <= '0;
         missc_ff <= '0;
         readc_ff <= '0;
         wbc_ff <= '0;
         policy_ff <= '0;
         chk_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         filled_ff <= filled_in;
         clock_ff <= clock_in;
         hitc_ff <= hitc_in;
         missc_ff <= missc_in;
         readc_ff <= readc_in;
         wbc_ff <= wbc_in;
         policy_ff <= policy_in;
         chk_valid_ff <= chk_valid_in;
      end
      is_write_ff <= is_write_in;
      page_ff <= page_in;
      issue_ff <= issue_in;
      chk_ff <= chk_in;
      best_ff <= best_in;
      best_stamp_ff <= best_stamp_in;
      best_dirty_ff <= best_dirty_in;
      best_cold_ff <= best_cold_in;
      best_page_ff <= best_page_in;
      have_ff <= have_in;
      rank_ff <= rank_in;
      frame_ff <= frame_in;
      hit_ff <= hit_in;
      ev_ff <= ev_in;
      wb_ff <= wb_in;
      evp_ff <= evp_in;
   end

   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_frame_index = pbr_pkg::FrameOutWidth'(frame_ff);
   assign rsp_hit = hit_ff;
   assign rsp_read_fetch = !hit_ff && !is_write_ff;
   assign rsp_evicted = ev_ff;
   assign rsp_writeback = wb_ff;
   assign rsp_evicted_page = evp_ff;
   assign rsp_hits_total = hitc_ff;
   assign rsp_misses_total = missc_ff;
   assign rsp_reads_total = readc_ff;
   assign rsp_writebacks_total = wbc_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= NumFramesC) else $error("fill count past frame count");
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> filled_ff == NumFramesC)
      else $error("eviction with free frames");
   a_wb_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_writeback |-> rsp_evicted && !rsp_hit)
      else $error("writeback without eviction");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held two cycles");
endmodule
